>>> design/vrpv_pkg.sv
// Shared types and constants for the video register port.
// Holds store sizes, item and register codes and the VRAM decode result type.
// No dependencies.
package vrpv_pkg;

    // Store sizes in bytes.
    localparam int SPRITE_MEM_BYTES   = 256;
    localparam int PATTERN_BANK_BYTES = 4096;
    localparam int NAME_BANK_BYTES    = 1024;
    localparam int PALETTE_BYTES      = 32;

    localparam int PATTERN_BYTES = 2 * PATTERN_BANK_BYTES;
    localparam int NAME_BYTES    = 2 * NAME_BANK_BYTES;

    localparam int SPRITE_AW  = $clog2(SPRITE_MEM_BYTES);
    localparam int PATTERN_AW = $clog2(PATTERN_BYTES);
    localparam int NAME_AW    = $clog2(NAME_BYTES);
    localparam int NAME_BW    = $clog2(NAME_BANK_BYTES);
    localparam int PALETTE_AW = $clog2(PALETTE_BYTES);

    // Upper address bits that mark the palette window.
    localparam logic [5:0] PALETTE_PAGE = 6'h3F;

    // Address step sizes for data register accesses.
    localparam logic [14:0] STEP_ACROSS = 15'd1;
    localparam logic [14:0] STEP_DOWN   = 15'd32;

    // Item kinds.
    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_STATUS = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Register numbers.
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Nametable mirroring codes.
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;

    // Which store a VRAM address lands in.
    typedef enum logic [1:0] {
        STORE_PATTERN = 2'd0,
        STORE_NAME    = 2'd1,
        STORE_PALETTE = 2'd2,
        STORE_NONE    = 2'd3
    } store_t;

    typedef struct packed {
        store_t                  store;
        logic [PATTERN_AW-1:0]   pattern_index;
        logic [NAME_AW-1:0]      name_index;
        logic [PALETTE_AW-1:0]   palette_index;
        logic                    palette_page;
    } vram_sel_t;

endpackage

>>> design/vrpv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vrpv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and a read port whose data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/vrpv_vram_decode.sv
// VRAM address decoder: maps a 15-bit address onto the pattern, nametable or
// palette store, applying nametable and palette mirroring. Uses vrpv_pkg.
module vrpv_vram_decode
    import vrpv_pkg::*;
(
    input  logic [14:0] address,
    input  logic [1:0]  mirror_mode,
    output vram_sel_t   sel
);

    logic name_bank;
    logic is_unmapped;

    // Bank choice follows the mirroring arrangement.
    always_comb
    begin
        name_bank   = 1'b0;
        is_unmapped = 1'b0;
        unique case (mirror_mode)
            MIRROR_VERTICAL:   name_bank = address[NAME_BW];
            MIRROR_HORIZONTAL: name_bank = address[NAME_BW+1];
            default:           is_unmapped = 1'b1;
        endcase
    end

    // Store selection on the low 14 bits; 0x3000..0x3EFF folds onto the nametables.
    always_comb
    begin
        sel.pattern_index = address[PATTERN_AW-1:0];
        sel.name_index    = {name_bank, address[NAME_BW-1:0]};
        sel.palette_page  = (address[13:8] == PALETTE_PAGE);
        // Entries 0x10, 0x14, 0x18 and 0x1C alias the background entries.
        if (address[4] && (address[1:0] == 2'b00))
        begin
            sel.palette_index = {1'b0, address[3:0]};
        end
        else
        begin
            sel.palette_index = address[PALETTE_AW-1:0];
        end

        if (!address[13])
        begin
            sel.store = STORE_PATTERN;
        end
        else if (sel.palette_page)
        begin
            sel.store = STORE_PALETTE;
        end
        else if (is_unmapped)
        begin
            sel.store = STORE_NONE;
        end
        else
        begin
            sel.store = STORE_NAME;
        end
    end

endmodule

>>> design/video_register_port_vram.sv
// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// item      | item_valid, item_stall, mode, reg_index,  | in
//           | write_data, status_flags                  |
// result    | result_valid, result_stall, read_data,    | out
//           | vram_address, control_value, mask_value,  |
//           | fine_x                                    |
// config    | cfg_valid, cfg_ready, mirror_mode         | in
//
// An accepted item launches the store reads; the execute state then applies the
// update and writes the stores back, using the registered read data of the
// synchronous RAMs.
// One item is in flight at a time; the next is accepted once the result of the
// previous one is registered, even if that result is still stalled.
// A stalled result holds the finishing item until the result register frees.
// Reset (rst_n, asynchronous) clears all control and scroll state; the stores
// are not cleared.
// Depends on vrpv_pkg, vrpv_ram and vrpv_vram_decode.
module video_register_port_vram
    import vrpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [2:0]  status_flags,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  read_data,
    output logic [14:0] vram_address,
    output logic [7:0]  control_value,
    output logic [7:0]  mask_value,
    output logic [2:0]  fine_x,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  mirror_mode
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;

    // Architectural state.
    logic [1:0]           mirror_reg;
    logic                 toggle_reg, toggle_next;
    logic [2:0]           fine_x_reg, fine_x_next;
    logic [14:0]          temp_reg, temp_next;
    logic [14:0]          current_reg, current_next;
    logic [7:0]           buffer_reg, buffer_next;
    logic [7:0]           control_reg, control_next;
    logic [7:0]           mask_reg, mask_next;
    logic [2:0]           status_reg, status_next;
    logic [SPRITE_AW-1:0] sprite_addr_reg, sprite_addr_next;

    // Result register.
    logic                 result_valid_reg, result_valid_next;
    logic [7:0]           read_data_reg, read_data_next;

    // Item held while it executes.
    mode_t                item_mode_reg;
    logic [2:0]           item_index_reg;
    logic [7:0]           item_data_reg;
    logic [2:0]           item_flags_reg;

    logic                 accept;
    logic                 complete;
    logic                 vram_write;
    logic [14:0]          step;
    logic [7:0]           vram_rdata;
    vram_sel_t            sel;

    logic [7:0]           sprite_rdata;
    logic [7:0]           pattern_rdata;
    logic [7:0]           name_rdata;
    logic [7:0]           palette_rdata;

    // Handshakes.
    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign complete   = (state_reg == ST_EXEC) && (!result_valid_reg || !result_stall);

    // Outputs: state registers change only when a new result is registered.
    assign result_valid  = result_valid_reg;
    assign read_data     = read_data_reg;
    assign vram_address  = current_reg;
    assign control_value = control_reg;
    assign mask_value    = mask_reg;
    assign fine_x        = fine_x_reg;

    // The current address is stable from accept to completion, so one decoder
    // serves both the read launch and the write-back.
    vrpv_vram_decode u_decode (
        .address     (current_reg),
        .mirror_mode (mirror_reg),
        .sel         (sel)
    );

    assign vram_write = complete && (item_mode_reg == MODE_WRITE)
                        && (item_index_reg == REG_DATA);

    vrpv_ram #(.WIDTH(8), .DEPTH(SPRITE_MEM_BYTES)) u_sprite_ram (
        .clk   (clk),
        .we    (complete && (item_mode_reg == MODE_WRITE)
                && (item_index_reg == REG_OAM_DATA)),
        .waddr (sprite_addr_reg),
        .wdata (item_data_reg),
        .re    (accept),
        .raddr (sprite_addr_reg),
        .rdata (sprite_rdata)
    );

    vrpv_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pattern_ram (
        .clk   (clk),
        .we    (vram_write && (sel.store == STORE_PATTERN)),
        .waddr (sel.pattern_index),
        .wdata (item_data_reg),
        .re    (accept),
        .raddr (sel.pattern_index),
        .rdata (pattern_rdata)
    );

    vrpv_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_ram (
        .clk   (clk),
        .we    (vram_write && (sel.store == STORE_NAME)),
        .waddr (sel.name_index),
        .wdata (item_data_reg),
        .re    (accept),
        .raddr (sel.name_index),
        .rdata (name_rdata)
    );

    vrpv_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_palette_ram (
        .clk   (clk),
        .we    (vram_write && (sel.store == STORE_PALETTE)),
        .waddr (sel.palette_index),
        .wdata (item_data_reg),
        .re    (accept),
        .raddr (sel.palette_index),
        .rdata (palette_rdata)
    );

    // Byte fetched from VRAM; unmapped nametables read as zero.
    always_comb
    begin
        unique case (sel.store)
            STORE_PATTERN: vram_rdata = pattern_rdata;
            STORE_NAME:    vram_rdata = name_rdata;
            STORE_PALETTE: vram_rdata = palette_rdata;
            default:       vram_rdata = 8'h00;
        endcase
    end

    // Address step of 1 or 32, wrapping at 15 bits.
    assign step = current_reg + (control_reg[2] ? STEP_DOWN : STEP_ACROSS);

    // State change on accept, and register update for the finishing item.
    always_comb
    begin
        state_next        = state_reg;
        toggle_next       = toggle_reg;
        fine_x_next       = fine_x_reg;
        temp_next         = temp_reg;
        current_next      = current_reg;
        buffer_next       = buffer_reg;
        control_next      = control_reg;
        mask_next         = mask_reg;
        status_next       = status_reg;
        sprite_addr_next  = sprite_addr_reg;
        read_data_next    = read_data_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (accept)
        begin
            state_next = ST_EXEC;
        end

        if (complete)
        begin
            state_next        = ST_IDLE;
            result_valid_next = 1'b1;
            read_data_next    = 8'h00;
            unique case (item_mode_reg)
                MODE_READ:
                begin
                    unique case (item_index_reg)
                        REG_STATUS:
                        begin
                            read_data_next = {status_reg, buffer_reg[4:0]};
                            status_next    = {1'b0, status_reg[1:0]};
                            toggle_next    = 1'b0;
                        end
                        REG_OAM_DATA:
                        begin
                            read_data_next = sprite_rdata;
                        end
                        REG_DATA:
                        begin
                            // Palette reads bypass the buffer.
                            read_data_next = sel.palette_page ? vram_rdata : buffer_reg;
                            buffer_next    = vram_rdata;
                            current_next   = step;
                        end
                        default:
                        begin
                            read_data_next = 8'h00;
                        end
                    endcase
                end
                MODE_WRITE:
                begin
                    unique case (item_index_reg)
                        REG_CTRL:
                        begin
                            control_next      = item_data_reg;
                            temp_next[11:10]  = item_data_reg[1:0];
                        end
                        REG_MASK:
                        begin
                            mask_next = item_data_reg;
                        end
                        REG_OAM_ADDR:
                        begin
                            sprite_addr_next = item_data_reg;
                        end
                        REG_OAM_DATA:
                        begin
                            sprite_addr_next = sprite_addr_reg + SPRITE_AW'(1);
                        end
                        REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                fine_x_next    = item_data_reg[2:0];
                                temp_next[4:0] = item_data_reg[7:3];
                                toggle_next    = 1'b1;
                            end
                            else
                            begin
                                temp_next[14:12] = item_data_reg[2:0];
                                temp_next[9:5]   = item_data_reg[7:3];
                                toggle_next      = 1'b0;
                            end
                        end
                        REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_next   = {1'b0, item_data_reg[5:0], temp_reg[7:0]};
                                toggle_next = 1'b1;
                            end
                            else
                            begin
                                temp_next    = {temp_reg[14:8], item_data_reg};
                                current_next = {temp_reg[14:8], item_data_reg};
                                toggle_next  = 1'b0;
                            end
                        end
                        REG_DATA:
                        begin
                            current_next = step;
                        end
                        default:
                        begin
                            toggle_next = toggle_reg;
                        end
                    endcase
                end
                MODE_STATUS:
                begin
                    status_next = status_reg | item_flags_reg;
                end
                MODE_NONE:
                begin
                    read_data_next = 8'h00;
                end
            endcase
        end
    end

    // State, control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mirror_reg       <= MIRROR_VERTICAL;
            toggle_reg       <= 1'b0;
            fine_x_reg       <= 3'd0;
            temp_reg         <= 15'd0;
            current_reg      <= 15'd0;
            buffer_reg       <= 8'h00;
            control_reg      <= 8'h00;
            mask_reg         <= 8'h00;
            status_reg       <= 3'd0;
            sprite_addr_reg  <= '0;
            result_valid_reg <= 1'b0;
            read_data_reg    <= 8'h00;
        end
        else
        begin
            state_reg        <= state_next;
            toggle_reg       <= toggle_next;
            fine_x_reg       <= fine_x_next;
            temp_reg         <= temp_next;
            current_reg      <= current_next;
            buffer_reg       <= buffer_next;
            control_reg      <= control_next;
            mask_reg         <= mask_next;
            status_reg       <= status_next;
            sprite_addr_reg  <= sprite_addr_next;
            result_valid_reg <= result_valid_next;
            read_data_reg    <= read_data_next;
            if (cfg_valid && cfg_ready)
            begin
                mirror_reg <= mirror_mode;
            end
        end
    end

    // Capture of the accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_mode_reg  <= mode_t'(mode);
            item_index_reg <= reg_index;
            item_data_reg  <= write_data;
            item_flags_reg <= status_flags;
        end
    end

endmodule

>>> tb/vram_port_checker.sv
// Checker for the video register port: watches the item, result and configuration
// channels, predicts every result and compares it field by field.
// Depends on vrpv_pkg.
module vram_port_checker
    import vrpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [2:0]  status_flags,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [7:0]  read_data,
    input  logic [14:0] vram_address,
    input  logic [7:0]  control_value,
    input  logic [7:0]  mask_value,
    input  logic [2:0]  fine_x,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  mirror_mode,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // What the port shows after one item.
    typedef struct packed {
        logic [7:0]  rd;
        logic [14:0] vaddr;
        logic [7:0]  ctrl;
        logic [7:0]  mask;
        logic [2:0]  fx;
    } port_view_t;

    port_view_t  due_views[$];
    port_view_t  oldest_view;
    int unsigned errors;

    // Private copy of the register port state.
    logic [1:0]  mirror_sel;
    logic        toggle;
    logic [2:0]  fine_q;
    logic [14:0] t_addr;
    logic [14:0] v_addr;
    logic [7:0]  rbuf;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [2:0]  status_q;
    logic [7:0]  oam_addr;

    logic [7:0]  oam_mem[SPRITE_MEM_BYTES];
    logic [7:0]  pattern_mem[PATTERN_BYTES];
    logic [7:0]  name_mem[NAME_BYTES];
    logic [7:0]  palette_mem[PALETTE_BYTES];

    // Palette entries 0x10, 0x14, 0x18 and 0x1C share storage with 0x00, 0x04, 0x08 and 0x0C.
    function automatic logic [4:0] palette_slot(input logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if ((p & 5'h13) == 5'h10)
        begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

    // Nametable slot under the current mirroring, or -1 when nothing is mapped.
    function automatic int name_slot(input logic [13:0] a);
        if (mirror_sel == MIRROR_VERTICAL)
        begin
            return int'({a[10], a[9:0]});
        end
        if (mirror_sel == MIRROR_HORIZONTAL)
        begin
            return int'({a[11], a[9:0]});
        end
        return -1;
    endfunction

    function automatic logic [7:0] vram_fetch(input logic [13:0] a);
        int slot;
        if (!a[13])
        begin
            return pattern_mem[a[12:0]];
        end
        if (a[13:8] == PALETTE_PAGE)
        begin
            return palette_mem[palette_slot(a)];
        end
        slot = name_slot(a);
        return (slot < 0) ? 8'h00 : name_mem[slot];
    endfunction

    function automatic void vram_store(input logic [13:0] a, input logic [7:0] d);
        int slot;
        if (!a[13])
        begin
            pattern_mem[a[12:0]] = d;
        end
        else if (a[13:8] == PALETTE_PAGE)
        begin
            palette_mem[palette_slot(a)] = d;
        end
        else
        begin
            slot = name_slot(a);
            if (slot >= 0)
            begin
                name_mem[slot] = d;
            end
        end
    endfunction

    // Data register accesses move across a row or down a column, wrapping at 15 bits.
    function automatic void step_vram_address();
        v_addr = v_addr + (ctrl_q[2] ? STEP_DOWN : STEP_ACROSS);
    endfunction

    // Applies one item to the private state and returns what the port should show.
    function automatic port_view_t apply_access(input logic [1:0] m, input logic [2:0] r,
                                                input logic [7:0] d, input logic [2:0] f);
        port_view_t  v;
        logic [13:0] a;
        v.rd = 8'h00;
        case (m)
            MODE_READ:
            begin
                case (r)
                    REG_STATUS:
                    begin
                        v.rd        = {status_q, rbuf[4:0]};
                        status_q[2] = 1'b0;
                        toggle      = 1'b0;
                    end
                    REG_OAM_DATA:
                    begin
                        v.rd = oam_mem[oam_addr];
                    end
                    REG_DATA:
                    begin
                        // Buffered read, except that palette bytes come straight back.
                        a    = v_addr[13:0];
                        v.rd = rbuf;
                        rbuf = vram_fetch(a);
                        if (a[13:8] == PALETTE_PAGE)
                        begin
                            v.rd = rbuf;
                        end
                        step_vram_address();
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_WRITE:
            begin
                case (r)
                    REG_CTRL:
                    begin
                        ctrl_q        = d;
                        t_addr[11:10] = d[1:0];
                    end
                    REG_MASK:
                    begin
                        mask_q = d;
                    end
                    REG_OAM_ADDR:
                    begin
                        oam_addr = d;
                    end
                    REG_OAM_DATA:
                    begin
                        oam_mem[oam_addr] = d;
                        oam_addr          = oam_addr + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!toggle)
                        begin
                            fine_q      = d[2:0];
                            t_addr[4:0] = d[7:3];
                        end
                        else
                        begin
                            t_addr[14:12] = d[2:0];
                            t_addr[9:5]   = d[7:3];
                        end
                        toggle = !toggle;
                    end
                    REG_ADDR:
                    begin
                        if (!toggle)
                        begin
                            t_addr = {1'b0, d[5:0], t_addr[7:0]};
                        end
                        else
                        begin
                            t_addr[7:0] = d;
                            v_addr      = t_addr;
                        end
                        toggle = !toggle;
                    end
                    REG_DATA:
                    begin
                        vram_store(v_addr[13:0], d);
                        step_vram_address();
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_STATUS:
            begin
                status_q = status_q | f;
            end
            default:
            begin
            end
        endcase
        v.vaddr = v_addr;
        v.ctrl  = ctrl_q;
        v.mask  = mask_q;
        v.fx    = fine_q;
        return v;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            errors++;
        end
    endfunction

    // Follow the channels, compare finished items and predict newly accepted ones.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_sel = MIRROR_VERTICAL;
            toggle     = 1'b0;
            fine_q     = 3'd0;
            t_addr     = 15'd0;
            v_addr     = 15'd0;
            rbuf       = 8'h00;
            ctrl_q     = 8'h00;
            mask_q     = 8'h00;
            status_q   = 3'd0;
            oam_addr   = 8'h00;
            errors     = 0;
            due_views.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mirror_sel = mirror_mode;
            end
            if (result_valid && !result_stall)
            begin
                if (due_views.size() == 0)
                begin
                    $error("result item with no item outstanding");
                    errors++;
                end
                else
                begin
                    oldest_view = due_views.pop_front();
                    check_field("read_data", 16'(oldest_view.rd), 16'(read_data));
                    check_field("vram_address", 16'(oldest_view.vaddr), 16'(vram_address));
                    check_field("control_value", 16'(oldest_view.ctrl), 16'(control_value));
                    check_field("mask_value", 16'(oldest_view.mask), 16'(mask_value));
                    check_field("fine_x", 16'(oldest_view.fx), 16'(fine_x));
                end
            end
            if (item_valid && !item_stall)
            begin
                due_views.push_back(apply_access(mode, reg_index, write_data, status_flags));
            end
            mismatches  <= errors;
            outstanding <= due_views.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Top of the video register port testbench: clock, reset, bus item stimulus and verdict.
// Fills a window of every store first, then runs directed and random phases under several
// idling patterns and mirroring modes. Depends on vrpv_pkg, the block and vram_port_checker.
module tb_top
    import vrpv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  MIRROR_UNMAPPED     = 2'd2;
    localparam logic [1:0]  MIRROR_UNMAPPED_ALT = 2'd3;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned WINDOW_BYTES = 256;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [1:0]  mode         = MODE_READ;
    logic [2:0]  reg_index    = REG_CTRL;
    logic [7:0]  write_data   = 8'h00;
    logic [2:0]  status_flags = 3'd0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  read_data;
    logic [14:0] vram_address;
    logic [7:0]  control_value;
    logic [7:0]  mask_value;
    logic [2:0]  fine_x;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  mirror_mode  = MIRROR_VERTICAL;

    int unsigned mismatches;
    int unsigned outstanding;

    int unsigned send_idle_pct    = 0;
    int unsigned result_stall_pct = 0;
    int unsigned items_sent       = 0;
    int unsigned hold_requests    = 0;
    int unsigned holds_served     = 0;
    int unsigned hold_left        = 0;
    int unsigned cycle_count      = 0;

    video_register_port_vram dut (.*);

    vram_port_checker port_check (.*);

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < result_stall_pct);
        end
    end

    // Offers one item, idling first at the phase's rate, and returns once it is taken.
    // Valid stays high afterwards so that back-to-back items need no gap.
    task automatic send_item(input mode_t m, input logic [2:0] r, input logic [7:0] d,
                             input logic [2:0] f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        mode         <= m;
        reg_index    <= r;
        write_data   <= d;
        status_flags <= f;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        items_sent++;
    endtask

    task automatic bus_write(input logic [2:0] r, input logic [7:0] d);
        send_item(MODE_WRITE, r, d, 3'($urandom_range(7)));
    endtask

    task automatic bus_read(input logic [2:0] r);
        send_item(MODE_READ, r, 8'($urandom_range(255)), 3'($urandom_range(7)));
    endtask

    // Stops offering and waits until every predicted result has been seen.
    task automatic drain_results();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    task automatic write_mirror(input logic [1:0] m);
        cfg_valid   <= 1'b1;
        mirror_mode <= m;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Points the VRAM address at a page and writes a run of random bytes from its start.
    task automatic fill_run(input logic [7:0] page, input int unsigned count);
        bus_write(REG_ADDR, page);
        bus_write(REG_ADDR, 8'h00);
        repeat (count)
        begin
            bus_write(REG_DATA, 8'($urandom_range(255)));
        end
    endtask

    // One short access pattern of the kind a CPU would issue, or now and then plain noise.
    task automatic random_burst();
        int unsigned pick;
        int unsigned count;
        logic [1:0]  top_bits;
        logic [1:0]  quarter;
        logic [1:0]  raw_mode;
        logic [2:0]  raw_reg;
        logic [7:0]  page;
        pick = $urandom_range(99);
        if (pick < 32)
        begin
            // Point the VRAM address into a filled window, then stream through the data
            // register. A status read first makes the address writes start in step.
            // Starting below 0x20, eight accesses stay within the page even at stride 32.
            bus_read(REG_STATUS);
            top_bits = 2'($urandom_range(3));
            quarter  = 2'($urandom_range(3));
            case ($urandom_range(3))
                0:       page = {top_bits, PALETTE_PAGE};
                1:       page = {top_bits, 2'b10, quarter, 2'b00};
                2:       page = {top_bits, 2'b11, quarter, 2'b00};
                default: page = {top_bits, 6'h00};
            endcase
            bus_write(REG_ADDR, page);
            bus_write(REG_ADDR, 8'($urandom_range(31)));
            count = $urandom_range(8, 1);
            repeat (count)
            begin
                if ($urandom_range(1))
                begin
                    bus_read(REG_DATA);
                end
                else
                begin
                    bus_write(REG_DATA, 8'($urandom_range(255)));
                end
            end
        end
        else if (pick < 44)
        begin
            bus_write(REG_SCROLL, 8'($urandom_range(255)));
            bus_write(REG_SCROLL, 8'($urandom_range(255)));
        end
        else if (pick < 54)
        begin
            bus_write(REG_CTRL, 8'($urandom_range(255)));
        end
        else if (pick < 60)
        begin
            bus_write(REG_MASK, 8'($urandom_range(255)));
        end
        else if (pick < 72)
        begin
            // Sprite memory: set the pointer, then a few data accesses.
            bus_write(REG_OAM_ADDR, 8'($urandom_range(255)));
            count = $urandom_range(4, 1);
            repeat (count)
            begin
                if ($urandom_range(1))
                begin
                    bus_read(REG_OAM_DATA);
                end
                else
                begin
                    bus_write(REG_OAM_DATA, 8'($urandom_range(255)));
                end
            end
        end
        else if (pick < 82)
        begin
            send_item(MODE_STATUS, 3'($urandom_range(7)), 8'($urandom_range(255)),
                      3'($urandom_range(7)));
            if ($urandom_range(1))
            begin
                bus_read(REG_STATUS);
            end
        end
        else if (pick < 88)
        begin
            bus_read(REG_STATUS);
        end
        else
        begin
            // A data register read here could land anywhere, so it becomes a status read.
            raw_mode = 2'($urandom_range(3));
            raw_reg  = 3'($urandom_range(7));
            if ((raw_mode == MODE_READ) && (raw_reg == REG_DATA))
            begin
                raw_reg = REG_STATUS;
            end
            send_item(mode_t'(raw_mode), raw_reg, 8'($urandom_range(255)),
                      3'($urandom_range(7)));
        end
    endtask

    // A random phase under one mirroring mode and one idling pattern.
    task automatic run_phase(input logic [1:0] mirror, input int unsigned idle_pct,
                             input int unsigned stall_pct, input bit long_hold);
        int unsigned start;
        bit          held;
        drain_results();
        write_mirror(mirror);
        send_idle_pct    = idle_pct;
        result_stall_pct = stall_pct;
        start            = items_sent;
        held             = 1'b0;
        while (items_sent - start < PHASE_ITEMS)
        begin
            if (long_hold && !held && (items_sent - start >= PHASE_ITEMS / 3))
            begin
                hold_requests++;
                held = 1'b1;
            end
            random_burst();
        end
    endtask

    initial
    begin
        repeat (2)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        write_mirror(MIRROR_VERTICAL);

        // Fill the first page of pattern memory, the first quarter of both nametable
        // banks, the whole palette and the whole sprite memory. Reads later stay inside
        // these windows, which cover the same nametable entries under either mirroring.
        bus_write(REG_CTRL, 8'h00);
        fill_run(8'h00, WINDOW_BYTES);
        fill_run(8'h20, WINDOW_BYTES);
        fill_run(8'h24, WINDOW_BYTES);
        fill_run({2'b00, PALETTE_PAGE}, PALETTE_BYTES);
        bus_write(REG_OAM_ADDR, 8'h00);
        repeat (SPRITE_MEM_BYTES)
        begin
            bus_write(REG_OAM_DATA, 8'($urandom_range(255)));
        end

        // Directed items: full-scale scroll and address writes leave the address at its
        // top, so the next data read uses the palette path and wraps at 15 bits.
        bus_write(REG_CTRL, 8'hFF);
        bus_write(REG_MASK, 8'hFF);
        bus_write(REG_ADDR, 8'hFF);
        bus_write(REG_SCROLL, 8'hFF);
        bus_write(REG_SCROLL, 8'hFF);
        bus_write(REG_ADDR, 8'hFF);
        bus_read(REG_DATA);
        bus_write(REG_CTRL, 8'h00);
        // Status flags are set by an event and vblank clears on the first read.
        send_item(MODE_STATUS, REG_CTRL, 8'h00, 3'b111);
        bus_read(REG_STATUS);
        bus_read(REG_STATUS);
        // Writes to the status register and reads of write-only registers change nothing.
        bus_write(REG_STATUS, 8'hA5);
        bus_read(REG_CTRL);
        bus_read(REG_MASK);
        bus_read(REG_ADDR);
        send_item(MODE_NONE, REG_DATA, 8'h5A, 3'b111);
        // Palette aliasing: a write to entry 0x10 is seen at entry 0x00.
        bus_write(REG_ADDR, {2'b00, PALETTE_PAGE});
        bus_write(REG_ADDR, 8'h10);
        bus_write(REG_DATA, 8'h00);
        bus_write(REG_ADDR, {2'b00, PALETTE_PAGE});
        bus_write(REG_ADDR, 8'h00);
        bus_read(REG_DATA);
        // Sprite pointer wraps from the last entry to the first.
        bus_write(REG_OAM_ADDR, 8'hFF);
        bus_write(REG_OAM_DATA, 8'hFF);
        bus_read(REG_OAM_DATA);
        // The 0x3000 window mirrors the nametables.
        bus_write(REG_ADDR, 8'h30);
        bus_write(REG_ADDR, 8'h00);
        bus_read(REG_DATA);

        // Random phases; the first also holds the result side off for a long stretch.
        run_phase(MIRROR_HORIZONTAL, 0, 0, 1'b1);
        run_phase(MIRROR_UNMAPPED, 78, 0, 1'b0);
        run_phase(MIRROR_VERTICAL, 0, 78, 1'b0);
        run_phase(MIRROR_HORIZONTAL, 24, 24, 1'b0);
        run_phase(MIRROR_UNMAPPED_ALT, 0, 0, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> video_register_port_vram.f
design/vrpv_pkg.sv
design/vrpv_ram.sv
design/vrpv_vram_decode.sv
design/video_register_port_vram.sv
tb/vram_port_checker.sv
tb/tb_top.sv
